// ===== rtl/multi_sensor_reading_qualifier_unit_defines.svh =====
// assertion macros used by the top-level rtl file
`ifndef MULTI_SENSOR_READING_QUALIFIER_UNIT_DEFINES_SVH
`define MULTI_SENSOR_READING_QUALIFIER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MSRQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define MSRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MSRQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define MSRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/msrq_pkg.sv =====
package msrq_pkg;

   localparam int SAMPLE_W  = 10;
   localparam int LIMIT_W   = 15;
   localparam int KIND_W    = 3;
   localparam int CSR_IDX_W = 2;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [LIMIT_W-1:0]  count_type;
   typedef logic [KIND_W-1:0]   kind_type;

   localparam kind_type KIND_AVERAGE  = 3'd0;
   localparam kind_type KIND_NO_DATA  = 3'd1;
   localparam kind_type KIND_WARNING  = 3'd2;
   localparam kind_type KIND_ONE_BAD  = 3'd3;
   localparam kind_type KIND_MANY_BAD = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_VALID_LOW     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_HIGH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAILURE_LIMIT = 2'd2;

   localparam sample_type VALID_LOW_RST  = 10'd280;
   localparam sample_type VALID_HIGH_RST = 10'd620;
   localparam count_type  LIMIT_RST      = 15'd0;

endpackage

// ===== rtl/msrq_ram.sv =====
module msrq_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 2
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/msrq_div.sv =====
module msrq_div
   import msrq_pkg::*;
#(
   parameter int CNT_W = 2,
   parameter int SUM_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output sample_type       quotient
);

   localparam int STEP_W = $clog2(SAMPLE_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   sample_type        q_ff, q_in;
   logic [CNT_W:0]    trial;
   logic              ge;

   // quotient fits in SAMPLE_W bits, so the high dividend bits start below the divisor
   always_comb begin
      trial   = {rem_ff, q_ff[SAMPLE_W-1]};
      ge      = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend[SUM_W-1:SAMPLE_W];
         q_in    = dividend[SAMPLE_W-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? CNT_W'(trial - {1'b0, dvs_ff}) : trial[CNT_W-1:0];
         q_in    = {q_ff[SAMPLE_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SAMPLE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== rtl/multi_sensor_reading_qualifier_unit.sv =====
// channel | dir | handshake                 | word
// req     | in  | req_valid / req_ready     | req_sample
// rsp     | out | rsp_valid / rsp_ready     | rsp_result_kind, rsp_moisture
// csr     | in  | csr_we (no wait)          | csr_index, csr_wdata
//
// one word at a time: accept, counter read-modify-write, a walk over the CHANNELS
// entries of both memories, then a status or no-data word goes straight out, while
// an average runs through the 10-step divider first
// per-entry valid bits make reset take effect at once, no clearing pass
// a finished word waits in the rsp register; a new word is accepted meanwhile
`include "multi_sensor_reading_qualifier_unit_defines.svh"

module multi_sensor_reading_qualifier_unit
   import msrq_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [SAMPLE_W-1:0]  req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_result_kind,
   output logic [SAMPLE_W-1:0]  rsp_moisture,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_wdata
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]          state_ff, state_in;
   sample_type          low_ff, low_in;
   sample_type          high_ff, high_in;
   count_type           limit_ff, limit_in;
   logic [CH_W-1:0]     chan_ff, chan_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   sample_type          sample_ff, sample_in;
   logic [CHANNELS-1:0] rd_vld_ff, rd_vld_in;
   logic [CHANNELS-1:0] cnt_vld_ff, cnt_vld_in;
   logic                fail_ff, fail_in;
   logic [CNT_W-1:0]    walk_ff, walk_in;
   logic                pend_ff, pend_in;
   logic [CH_W-1:0]     pidx_ff, pidx_in;
   logic [1:0]          nbad_ff, nbad_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    num_ff, num_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   sample_type          rsp_moist_ff, rsp_moist_in;
   kind_type            kind_ff, kind_in;
   sample_type          moist_ff, moist_in;

   logic                rd_we, cnt_we;
   logic [CH_W-1:0]     raddr;
   sample_type          rd_q;
   count_type           cnt_q, cnt_wdata;
   count_type           c_cur, cap;
   logic [LIMIT_W:0]    c_inc;
   sample_type          r_cur;
   logic                check_on, out_band, div_start, div_done;
   sample_type          div_q;

   msrq_ram #(.WIDTH(SAMPLE_W), .DEPTH(CHANNELS)) u_readings (
      .clock (clock),
      .we    (rd_we),
      .waddr (ch_ff),
      .wdata (sample_ff),
      .raddr (raddr),
      .rdata (rd_q)
   );

   msrq_ram #(.WIDTH(LIMIT_W), .DEPTH(CHANNELS)) u_counters (
      .clock (clock),
      .we    (cnt_we),
      .waddr (ch_ff),
      .wdata (cnt_wdata),
      .raddr (raddr),
      .rdata (cnt_q)
   );

   msrq_div #(.CNT_W(CNT_W), .SUM_W(SUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (num_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign check_on  = ~limit_ff[LIMIT_W-1];
   assign cap       = {limit_ff[LIMIT_W-2:0], 1'b0};
   assign out_band  = (sample_ff < low_ff) || (sample_ff > high_ff);

   // entries never written since reset read as zero
   always_comb begin
      if (state_ff == ST_CHECK) begin
         c_cur = cnt_vld_ff[ch_ff] ? cnt_q : '0;
      end else begin
         c_cur = cnt_vld_ff[pidx_ff] ? cnt_q : '0;
      end
      r_cur = rd_vld_ff[pidx_ff] ? rd_q : '0;
      c_inc = {1'b0, c_cur} + 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      limit_in     = limit_ff;
      chan_in      = chan_ff;
      ch_in        = ch_ff;
      sample_in    = sample_ff;
      rd_vld_in    = rd_vld_ff;
      cnt_vld_in   = cnt_vld_ff;
      fail_in      = fail_ff;
      walk_in      = walk_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      nbad_in      = nbad_ff;
      sum_in       = sum_ff;
      num_in       = num_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_moist_in = rsp_moist_ff;
      kind_in      = kind_ff;
      moist_in     = moist_ff;
      rd_we        = 1'b0;
      cnt_we       = 1'b0;
      cnt_wdata    = c_cur;
      raddr        = chan_ff;
      div_start    = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_VALID_LOW:     low_in   = csr_wdata[SAMPLE_W-1:0];
            CSR_VALID_HIGH:    high_in  = csr_wdata[SAMPLE_W-1:0];
            CSR_FAILURE_LIMIT: limit_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               ch_in     = chan_ff;
               chan_in   = (chan_ff == CH_W'(CHANNELS - 1)) ? '0 : chan_ff + 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // counter update: up on an out-of-band sample, saturating at twice the limit, else down to zero
            if (out_band) begin
               cnt_wdata = (c_inc > {1'b0, cap}) ? cap : c_inc[LIMIT_W-1:0];
            end else begin
               cnt_wdata = (c_cur != '0) ? c_cur - 1'b1 : c_cur;
            end
            cnt_we           = check_on;
            if (check_on) begin
               cnt_vld_in[ch_ff] = 1'b1;
            end
            rd_we            = 1'b1;
            rd_vld_in[ch_ff] = 1'b1;
            fail_in          = check_on && out_band;
            walk_in          = '0;
            nbad_in          = '0;
            sum_in           = '0;
            num_in           = '0;
            state_in         = ST_WALK;
         end
         ST_WALK: begin
            raddr = walk_ff[CH_W-1:0];
            if (walk_ff < CNT_W'(CHANNELS)) begin
               pend_in = 1'b1;
               pidx_in = walk_ff[CH_W-1:0];
               walk_in = walk_ff + 1'b1;
            end
            if (pend_ff) begin
               if (fail_ff) begin
                  if ({1'b0, c_cur} > {2'b00, limit_ff[LIMIT_W-2:0]} && nbad_ff != 2'd2) begin
                     nbad_in = nbad_ff + 1'b1;
                  end
               end else if (r_cur > low_ff && r_cur < high_ff) begin
                  sum_in = sum_ff + SUM_W'(r_cur);
                  num_in = num_ff + 1'b1;
               end
               if (pidx_ff == CH_W'(CHANNELS - 1)) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            moist_in = '0;
            state_in = ST_OUT;
            if (fail_ff) begin
               case (nbad_ff)
                  2'd0:    kind_in = KIND_WARNING;
                  2'd1:    kind_in = KIND_ONE_BAD;
                  default: kind_in = KIND_MANY_BAD;
               endcase
            end else if (num_ff == '0) begin
               kind_in = KIND_NO_DATA;
            end else begin
               kind_in   = KIND_AVERAGE;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               moist_in = div_q;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_moist_in = moist_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= VALID_LOW_RST;
         high_ff      <= VALID_HIGH_RST;
         limit_ff     <= LIMIT_RST;
         chan_ff      <= '0;
         rd_vld_ff    <= '0;
         cnt_vld_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         limit_ff     <= limit_in;
         chan_ff      <= chan_in;
         rd_vld_ff    <= rd_vld_in;
         cnt_vld_ff   <= cnt_vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff        <= ch_in;
      sample_ff    <= sample_in;
      fail_ff      <= fail_in;
      walk_ff      <= walk_in;
      pidx_ff      <= pidx_in;
      nbad_ff      <= nbad_in;
      sum_ff       <= sum_in;
      num_ff       <= num_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_moist_ff <= rsp_moist_in;
      kind_ff      <= kind_in;
      moist_ff     <= moist_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_moisture    = rsp_moist_ff;

   // an average only counts readings above the low bound, so it is never zero
   `MSRQ_ASSERT_IMPLY(a_avg_nonzero, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_AVERAGE, rsp_moist_ff != '0, "average word with zero moisture")
   `MSRQ_ASSERT_IMPLY(a_status_zero, clock, reset, rsp_valid_ff && rsp_kind_ff != KIND_AVERAGE, rsp_moist_ff == '0, "status word with nonzero moisture")
   `MSRQ_ASSERT_NEXT(a_chan_step, clock, reset, req_valid && req_ready, (CHANNELS == 1) || (chan_ff != $past(chan_ff)), "channel index did not advance")
   `MSRQ_ASSERT_IMPLY(a_div_state, clock, reset, div_done, state_ff == ST_DIV, "divider finished outside divide state")

endmodule
